FILE: hw/rtl/jsm_pkg.sv
// Shared constants and command codes for the job-shop makespan evaluator.
`default_nettype none
package jsm_pkg;

  localparam int MAX_MACHINES_DEF   = 16;
  localparam int MAX_TASKS_DEF      = 16;
  localparam int MAX_OPERATIONS_DEF = 256;
  localparam int TIME_BITS_DEF      = 16;

  localparam int END_BITS = 24;
  localparam logic [END_BITS-1:0] END_MAX = 24'hFF_FFFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

endpackage
`default_nettype wire

FILE: hw/rtl/jsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hw/rtl/job_shop_makespan_evaluator.sv
// Job-shop makespan evaluator: top level with operation table and end-time memories.
// A step reads the op table, then the end-time RAMs; a last step registers the makespan.
// Throughput: one word per cycle; the three-stage read-modify-write path through the
// end-time RAMs forwards the previous write, so same machine or task back to back is fine.
// Input stalls only while a sequence-ending step waits behind an untaken result.
// Reset (synchronous, rst_n low) clears valid bits, running maximum and pipeline
// valids; no clearing pass is needed. The operation table is undefined until loaded.
`default_nettype none
module job_shop_makespan_evaluator #(
  parameter int MAX_MACHINES   = jsm_pkg::MAX_MACHINES_DEF,
  parameter int MAX_TASKS      = jsm_pkg::MAX_TASKS_DEF,
  parameter int MAX_OPERATIONS = jsm_pkg::MAX_OPERATIONS_DEF,
  parameter int TIME_BITS      = jsm_pkg::TIME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_op_index,
  input  wire logic [3:0]  in_entry_machine,
  input  wire logic [3:0]  in_entry_task,
  input  wire logic [15:0] in_entry_time,
  input  wire logic        in_first_in_sequence,
  input  wire logic        in_last_in_sequence,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      out_makespan
);

  localparam int EB = jsm_pkg::END_BITS;
  localparam int OW = (MAX_OPERATIONS > 1) ? $clog2(MAX_OPERATIONS) : 1;
  localparam int MW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int ENTRY_W = 8 + TIME_BITS;
  localparam int SW = ((TIME_BITS > EB) ? TIME_BITS : EB) + 1;

  // stage 0: accept, table write or read
  logic              adv;
  logic              acc;
  logic              idx_ok;
  logic [31:0]       idx_ext;
  logic [31:0]       time_ext;
  logic [OW-1:0]     tbl_addr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [ENTRY_W-1:0] tbl_rdata;

  // stage 1
  logic              s1_valid_r;
  logic              s1_idx_ok_r;
  logic              s1_first_r;
  logic              s1_last_r;
  logic [3:0]        s1_mach;
  logic [3:0]        s1_task;
  logic [31:0]       s1_mach_ext;
  logic [31:0]       s1_task_ext;
  logic              s1_ok;

  // stage 2
  logic              s2_valid_r;
  logic              s2_ok_r;
  logic              s2_first_r;
  logic              s2_last_r;
  logic [MW-1:0]     s2_maddr_r;
  logic [TW-1:0]     s2_taddr_r;
  logic [TIME_BITS-1:0] s2_time_r;
  logic [EB-1:0]     mend_rdata;
  logic [EB-1:0]     tend_rdata;
  logic [EB-1:0]     me_raw;
  logic [EB-1:0]     te_raw;
  logic [EB-1:0]     me;
  logic [EB-1:0]     te;
  logic [EB-1:0]     start;
  logic [SW-1:0]     sum;
  logic [EB-1:0]     fin;
  logic              do_write;

  // forwarding of the last committed write
  logic              fwd_v_r;
  logic [MW-1:0]     fwd_m_r;
  logic [TW-1:0]     fwd_t_r;
  logic [EB-1:0]     fwd_fin_r;

  logic [MAX_MACHINES-1:0] mwritten_r;
  logic [MAX_MACHINES-1:0] mwritten_nxt;
  logic [MAX_TASKS-1:0]    twritten_r;
  logic [MAX_TASKS-1:0]    twritten_nxt;
  logic [EB-1:0]           max_r;
  logic [EB-1:0]           max_base;
  logic [EB-1:0]           max_nxt;

  logic              out_valid_r;
  logic [EB-1:0]     out_makespan_r;

  // stall only when a result-producing step meets a full output register
  assign adv      = !(s2_valid_r && s2_last_r && out_valid_r && !out_ready);
  assign in_ready = adv;
  assign acc      = in_valid && adv;

  assign idx_ext   = 32'(in_op_index);
  assign time_ext  = 32'(in_entry_time);
  assign idx_ok    = (idx_ext < 32'(MAX_OPERATIONS));
  assign tbl_addr  = idx_ext[OW-1:0];
  assign tbl_wdata = {in_entry_machine, in_entry_task, time_ext[TIME_BITS-1:0]};

  jsm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_OPERATIONS)
  ) u_table (
    .clk  (clk),
    .we   (acc && (in_command == jsm_pkg::CMD_LOAD) && idx_ok),
    .waddr(tbl_addr),
    .wdata(tbl_wdata),
    .re   (acc && (in_command == jsm_pkg::CMD_STEP)),
    .raddr(tbl_addr),
    .rdata(tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid && (in_command == jsm_pkg::CMD_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_ok_r <= idx_ok;
      s1_first_r  <= in_first_in_sequence;
      s1_last_r   <= in_last_in_sequence;
    end
  end

  assign s1_mach     = tbl_rdata[ENTRY_W-1 -: 4];
  assign s1_task     = tbl_rdata[ENTRY_W-5 -: 4];
  assign s1_mach_ext = 32'(s1_mach);
  assign s1_task_ext = 32'(s1_task);
  assign s1_ok       = s1_idx_ok_r && (s1_mach_ext < 32'(MAX_MACHINES)) &&
                       (s1_task_ext < 32'(MAX_TASKS));

  jsm_ram #(
    .WIDTH(EB),
    .DEPTH(MAX_MACHINES)
  ) u_machine_end (
    .clk  (clk),
    .we   (adv && do_write),
    .waddr(s2_maddr_r),
    .wdata(fin),
    .re   (adv && s1_valid_r),
    .raddr(s1_mach_ext[MW-1:0]),
    .rdata(mend_rdata)
  );

  jsm_ram #(
    .WIDTH(EB),
    .DEPTH(MAX_TASKS)
  ) u_task_end (
    .clk  (clk),
    .we   (adv && do_write),
    .waddr(s2_taddr_r),
    .wdata(fin),
    .re   (adv && s1_valid_r),
    .raddr(s1_task_ext[TW-1:0]),
    .rdata(tend_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ok_r    <= s1_ok;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_maddr_r <= s1_mach_ext[MW-1:0];
      s2_taddr_r <= s1_task_ext[TW-1:0];
      s2_time_r  <= tbl_rdata[TIME_BITS-1:0];
    end
  end

  // the RAM read raced the previous write: take the forwarded value on a match
  assign me_raw = (fwd_v_r && (fwd_m_r == s2_maddr_r)) ? fwd_fin_r : mend_rdata;
  assign te_raw = (fwd_v_r && (fwd_t_r == s2_taddr_r)) ? fwd_fin_r : tend_rdata;
  assign me     = (!s2_first_r && mwritten_r[s2_maddr_r]) ? me_raw : '0;
  assign te     = (!s2_first_r && twritten_r[s2_taddr_r]) ? te_raw : '0;
  assign start  = (me > te) ? me : te;
  assign sum    = SW'(start) + SW'(s2_time_r);
  assign fin    = (sum > SW'(jsm_pkg::END_MAX)) ? jsm_pkg::END_MAX : sum[EB-1:0];
  assign do_write = s2_valid_r && s2_ok_r;

  always_comb begin
    mwritten_nxt = s2_first_r ? '0 : mwritten_r;
    twritten_nxt = s2_first_r ? '0 : twritten_r;
    max_base     = s2_first_r ? '0 : max_r;
    max_nxt      = max_base;
    if (do_write) begin
      mwritten_nxt = mwritten_nxt | (MAX_MACHINES'(1) << s2_maddr_r);
      twritten_nxt = twritten_nxt | (MAX_TASKS'(1) << s2_taddr_r);
      if (fin > max_base) begin
        max_nxt = fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mwritten_r <= '0;
      twritten_r <= '0;
      max_r      <= '0;
      fwd_v_r    <= 1'b0;
    end else if (adv) begin
      fwd_v_r <= do_write;
      if (s2_valid_r) begin
        mwritten_r <= mwritten_nxt;
        twritten_r <= twritten_nxt;
        max_r      <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && do_write) begin
      fwd_m_r   <= s2_maddr_r;
      fwd_t_r   <= s2_taddr_r;
      fwd_fin_r <= fin;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s2_valid_r && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_last_r) begin
      out_makespan_r <= max_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_makespan = out_makespan_r;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s2_valid_r && s2_last_r && out_valid_r))
    else $error("input stalled without a blocked result");

  a_fwd_in_max: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_v_r |-> (max_r >= fwd_fin_r))
    else $error("running maximum below last end time");

  a_fwd_marked: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_v_r |-> (mwritten_r[fwd_m_r] && twritten_r[fwd_t_r]))
    else $error("forwarded end time not marked written");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && s2_last_r) |=> out_valid_r)
    else $error("sequence end gave no result");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the job-shop makespan evaluator.
`timescale 1ns / 1ps
module tb;

  class makespan_scoreboard;
    bit [3:0]                  op_machine [256];
    bit [3:0]                  op_task    [256];
    bit [15:0]                 op_time    [256];
    bit [jsm_pkg::END_BITS-1:0] machine_end[16];
    bit [jsm_pkg::END_BITS-1:0] task_end   [16];
    bit [15:0]                 machine_live;
    bit [15:0]                 task_live;
    bit [jsm_pkg::END_BITS-1:0] peak_end;
    bit [jsm_pkg::END_BITS-1:0] makespan_q[$];
    int n_errors;
    int n_loads;
    int n_steps;
    int n_results;
    int n_saturated;

    // Update the schedule for one accepted word; queue a makespan on a last step.
    function void note_word(bit cmd, bit [7:0] idx, bit [3:0] mach, bit [3:0] tsk,
                            bit [15:0] dur, bit first, bit last);
      bit [3:0]                   m;
      bit [3:0]                   t;
      bit [jsm_pkg::END_BITS-1:0] me;
      bit [jsm_pkg::END_BITS-1:0] te;
      bit [jsm_pkg::END_BITS-1:0] start;
      bit [jsm_pkg::END_BITS:0]   sum;
      bit [jsm_pkg::END_BITS-1:0] fin;
      if (cmd == jsm_pkg::CMD_LOAD) begin
        op_machine[idx] = mach;
        op_task[idx]    = tsk;
        op_time[idx]    = dur;
        n_loads++;
        return;
      end
      n_steps++;
      if (first) begin
        machine_live = '0;
        task_live    = '0;
        peak_end     = '0;
      end
      m     = op_machine[idx];
      t     = op_task[idx];
      me    = machine_live[m] ? machine_end[m] : '0;
      te    = task_live[t] ? task_end[t] : '0;
      start = (me > te) ? me : te;
      sum   = {1'b0, start} + {9'd0, op_time[idx]};
      fin   = (sum > {1'b0, jsm_pkg::END_MAX}) ? jsm_pkg::END_MAX
                                               : sum[jsm_pkg::END_BITS-1:0];
      machine_end[m]  = fin;
      task_end[t]     = fin;
      machine_live[m] = 1'b1;
      task_live[t]    = 1'b1;
      if (fin > peak_end) peak_end = fin;
      if (last) begin
        makespan_q = {makespan_q, peak_end};
        if (peak_end == jsm_pkg::END_MAX) n_saturated++;
      end
    endfunction

    function void check_makespan(bit [jsm_pkg::END_BITS-1:0] got);
      bit [jsm_pkg::END_BITS-1:0] want;
      n_results++;
      if (makespan_q.size() == 0) begin
        $display("%0t: unexpected makespan word, expected none, actual %0d", $time, got);
        n_errors++;
        return;
      end
      want = makespan_q.pop_front();
      if (got !== want) begin
        $display("%0t: makespan mismatch, expected %0d, actual %0d", $time, want, got);
        n_errors++;
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = jsm_pkg::CMD_LOAD;
  logic [7:0]  in_op_index = '0;
  logic [3:0]  in_entry_machine = '0;
  logic [3:0]  in_entry_task = '0;
  logic [15:0] in_entry_time = '0;
  logic        in_first_in_sequence = 1'b0;
  logic        in_last_in_sequence = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_makespan;

  makespan_scoreboard sb;
  int send_idle_pct = 19;
  int recv_idle_pct = 50;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit is_loaded[256];
  int loaded_q[$];

  job_shop_makespan_evaluator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_op_index         (in_op_index),
    .in_entry_machine    (in_entry_machine),
    .in_entry_task       (in_entry_task),
    .in_entry_time       (in_entry_time),
    .in_first_in_sequence(in_first_in_sequence),
    .in_last_in_sequence (in_last_in_sequence),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_makespan        (out_makespan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when asked for one.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_makespan(out_makespan);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic cmd, input logic [7:0] idx, input logic [3:0] mach,
                           input logic [3:0] tsk, input logic [15:0] dur,
                           input logic first, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_command           <= cmd;
    in_op_index          <= idx;
    in_entry_machine     <= mach;
    in_entry_task        <= tsk;
    in_entry_time        <= dur;
    in_first_in_sequence <= first;
    in_last_in_sequence  <= last;
    in_valid             <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(cmd, idx, mach, tsk, dur, first, last);
    if (cmd == jsm_pkg::CMD_LOAD && !is_loaded[idx]) begin
      is_loaded[idx] = 1'b1;
      loaded_q = {loaded_q, int'(idx)};
    end
  endtask

  // Step a loaded entry; the load-only fields carry noise.
  task automatic step_op(input logic [7:0] idx, input logic first, input logic last);
    send_word(jsm_pkg::CMD_STEP, idx, 4'($urandom), 4'($urandom), 16'($urandom),
              first, last);
  endtask

  task automatic load_random();
    logic [3:0]  mach;
    logic [3:0]  tsk;
    logic [15:0] dur;
    mach = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom);
    tsk  = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom);
    case ($urandom_range(3))
      0:       dur = 16'hFFFF;
      1:       dur = 16'($urandom);
      default: dur = 16'($urandom_range(40));
    endcase
    send_word(jsm_pkg::CMD_LOAD, 8'($urandom), mach, tsk, dur, 1'($urandom), 1'($urandom));
  endtask

  function automatic logic [7:0] pick_loaded();
    return 8'(loaded_q[$urandom_range(loaded_q.size() - 1)]);
  endfunction

  // Mostly well-formed sequences, with loads in between and stray steps.
  task automatic run_random(input int n_words);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(99);
      if (r < 25) begin
        load_random();
        sent++;
      end else if (r < 90) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) begin
            load_random();
            sent++;
          end
          step_op(pick_loaded(), i == 0, i == len - 1);
          sent++;
        end
      end else begin
        step_op(pick_loaded(), 1'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  // Drive one machine past the end-time ceiling with maximum-length operations.
  task automatic run_saturation(input int n_steps);
    for (int i = 0; i < 4; i++)
      send_word(jsm_pkg::CMD_LOAD, 8'(200 + i), 4'd7, 4'(i), 16'hFFFF, 0, 0);
    for (int i = 0; i < n_steps; i++)
      step_op(8'(200 + $urandom_range(3)), i == 0,
              (i == n_steps - 1) || ($urandom_range(15) == 0));
  endtask

  initial begin
    sb = new;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, flags on load, continuation without first, load then use.
    send_word(jsm_pkg::CMD_LOAD, 8'd0,   4'd0,  4'd0,  16'h0000, 1, 1);
    send_word(jsm_pkg::CMD_LOAD, 8'd255, 4'd15, 4'd15, 16'hFFFF, 0, 0);
    send_word(jsm_pkg::CMD_LOAD, 8'd1,   4'd15, 4'd0,  16'h0001, 0, 1);
    send_word(jsm_pkg::CMD_LOAD, 8'd2,   4'd0,  4'd15, 16'h8000, 1, 0);
    send_word(jsm_pkg::CMD_LOAD, 8'd128, 4'd10, 4'd5,  16'h5555, 0, 0);
    step_op(8'd255, 1, 1);
    step_op(8'd0,   1, 1);
    step_op(8'd1,   1, 0);
    step_op(8'd255, 0, 0);
    step_op(8'd2,   0, 0);
    step_op(8'd0,   0, 1);
    step_op(8'd1,   0, 1);
    step_op(8'd128, 1, 1);
    send_word(jsm_pkg::CMD_LOAD, 8'd1, 4'd3, 4'd3, 16'd7, 0, 0);
    step_op(8'd1,   1, 1);
    step_op(8'd2,   0, 1);
    step_op(8'd2,   0, 0);
    step_op(8'd128, 1, 0);
    step_op(8'd128, 0, 1);

    run_random(120);

    send_idle_pct = 50;
    recv_idle_pct = 19;
    run_random(120);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(80);
    run_saturation(262);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.makespan_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads and %0d steps; %0d makespans checked, %0d at the ceiling.",
             sb.n_loads, sb.n_steps, sb.n_results, sb.n_saturated);
    $display("Idle patterns: sender-light, receiver-light, none, plus a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (sb.n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
